@@ rtl/u8250_pkg.sv @@
// Shared types and constants for the 8250 UART register model.
package u8250_pkg;

  // I/O window 0x3F8..0x3FF: upper 13 address bits select the window
  localparam logic [12:0] UART_PAGE     = 13'h07F;
  localparam logic [7:0]  DLAB_BIT      = 8'h80;
  localparam logic [7:0]  LSR_TX_EMPTY  = 8'h60;
  localparam logic [7:0]  LSR_KEEP_MASK = 8'h61;
  localparam logic [7:0]  LSR_DR        = 8'h01;
  localparam logic [7:0]  LSR_OE        = 8'h02;
  localparam logic [7:0]  MCR_RTS       = 8'h02;
  localparam logic [7:0]  IIR_IDLE      = 8'h01;
  localparam logic [7:0]  MSR_RESET     = 8'h30;
  localparam logic [7:0]  MOUSE_ID      = 8'h4D;

  typedef enum logic {
    OP_READ  = 1'b0,
    OP_WRITE = 1'b1
  } op_e;

  typedef enum logic [2:0] {
    OFF_RBR = 3'd0,
    OFF_IER = 3'd1,
    OFF_IIR = 3'd2,
    OFF_LCR = 3'd3,
    OFF_MCR = 3'd4,
    OFF_LSR = 3'd5,
    OFF_MSR = 3'd6,
    OFF_SCR = 3'd7
  } reg_off_e;

  typedef struct packed {
    op_e         op;
    logic [15:0] port;
    logic [7:0]  write_data;
  } access_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       hit;
  } result_t;

endpackage

@@ rtl/uart_8250_register_model.sv @@
// Path: an input transaction passes through the input register, then the result register,
// before its result is offered on the master side.
// Throughput: one bus access per cycle; the input and result registers
// advance together whenever the result register is empty or being taken.
// Reset: asynchronous active low; registers take their 8250 reset values
// (IIR 0x01, LSR 0x60, MSR 0x30, others zero) and both stages empty.
module uart_8250_register_model (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,  // [15:0] port, [23:16] write_data
  input  logic        s_axis_tuser,  // [0] op
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,  // [7:0] read_data
  output logic        m_axis_tuser   // [0] hit
);
  import u8250_pkg::*;

  logic     in_vld_q;
  access_t  in_acc_q;
  logic     out_vld_q;
  result_t  out_res_q;
  result_t  res;
  logic     out_ready;
  logic     advance;

  assign out_ready     = !out_vld_q || m_axis_tready;
  assign s_axis_tready = !in_vld_q || out_ready;
  assign advance       = in_vld_q && out_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (s_axis_tready) in_vld_q <= s_axis_tvalid;
      if (out_ready)     out_vld_q <= in_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_acc_q.op         <= op_e'(s_axis_tuser);
      in_acc_q.port       <= s_axis_tdata[15:0];
      in_acc_q.write_data <= s_axis_tdata[23:16];
    end
    if (advance) out_res_q <= res;
  end

  u8250_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .strobe_i(advance),
    .acc_i   (in_acc_q),
    .res_o   (res)
  );

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_res_q.read_data;
  assign m_axis_tuser  = out_res_q.hit;

endmodule

@@ rtl/u8250_regs.sv @@
// UART register file: address decode, side effects and read mux for one access.
module u8250_regs (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               strobe_i,
  input  u8250_pkg::access_t acc_i,
  output u8250_pkg::result_t res_o
);
  import u8250_pkg::*;

  logic [7:0] rbr_q, rbr_d;
  logic [7:0] thr_q, thr_d;
  logic [7:0] ier_q, ier_d;
  logic [7:0] iir_q, iir_d;
  logic [7:0] lcr_q, lcr_d;
  logic [7:0] mcr_q, mcr_d;
  logic [7:0] lsr_q, lsr_d;
  logic [7:0] msr_q, msr_d;
  logic [7:0] scr_q, scr_d;
  logic [7:0] dll_q, dll_d;
  logic [7:0] dlm_q, dlm_d;

  logic       hit;
  logic       dlab;
  reg_off_e   off;
  logic [7:0] rising;
  logic [7:0] rd;

  assign hit    = (acc_i.port[15:3] == UART_PAGE);
  assign dlab   = |(lcr_q & DLAB_BIT);
  assign off    = reg_off_e'(acc_i.port[2:0]);
  assign rising = ~mcr_q & acc_i.write_data;

  always_comb begin
    rbr_d = rbr_q;
    thr_d = thr_q;
    ier_d = ier_q;
    iir_d = iir_q;
    lcr_d = lcr_q;
    mcr_d = mcr_q;
    lsr_d = lsr_q;
    msr_d = msr_q;
    scr_d = scr_q;
    dll_d = dll_q;
    dlm_d = dlm_q;
    rd    = 8'h00;
    if (hit) begin
      if (acc_i.op == OP_WRITE) begin
        case (off)
          OFF_RBR: begin
            if (dlab) begin
              dll_d = acc_i.write_data;
            end else begin
              thr_d = acc_i.write_data;
              lsr_d = lsr_q & ~LSR_TX_EMPTY;
            end
          end
          OFF_IER: begin
            if (dlab) dlm_d = acc_i.write_data;
            else      ier_d = acc_i.write_data;
          end
          OFF_LCR: lcr_d = acc_i.write_data;
          OFF_MCR: begin
            mcr_d = acc_i.write_data;
            // RTS rising: serial mouse identifies itself
            if (|(rising & MCR_RTS)) begin
              rbr_d = MOUSE_ID;
              lsr_d = lsr_q | LSR_DR | ((|(lsr_q & LSR_DR)) ? LSR_OE : 8'h00);
            end
          end
          OFF_LSR: lsr_d = acc_i.write_data;
          OFF_MSR: msr_d = acc_i.write_data;
          OFF_SCR: scr_d = acc_i.write_data;
          default: ; // IIR is read-only
        endcase
      end else begin
        case (off)
          OFF_RBR: begin
            if (dlab) begin
              rd = dll_q;
            end else begin
              rd    = rbr_q;
              lsr_d = lsr_q & ~LSR_DR;
            end
          end
          OFF_IER: rd = dlab ? dlm_q : ier_q;
          OFF_IIR: begin
            rd    = iir_q;
            iir_d = IIR_IDLE;
          end
          OFF_LCR: rd = lcr_q;
          OFF_MCR: rd = mcr_q;
          OFF_LSR: begin
            rd    = lsr_q;
            lsr_d = lsr_q & LSR_KEEP_MASK;
          end
          OFF_MSR: rd = msr_q;
          default: rd = scr_q;
        endcase
      end
    end
  end

  assign res_o.read_data = rd;
  assign res_o.hit       = hit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rbr_q <= 8'h00;
      thr_q <= 8'h00;
      ier_q <= 8'h00;
      iir_q <= IIR_IDLE;
      lcr_q <= 8'h00;
      mcr_q <= 8'h00;
      lsr_q <= LSR_TX_EMPTY;
      msr_q <= MSR_RESET;
      scr_q <= 8'h00;
      dll_q <= 8'h00;
      dlm_q <= 8'h00;
    end else if (strobe_i) begin
      rbr_q <= rbr_d;
      thr_q <= thr_d;
      ier_q <= ier_d;
      iir_q <= iir_d;
      lcr_q <= lcr_d;
      mcr_q <= mcr_d;
      lsr_q <= lsr_d;
      msr_q <= msr_d;
      scr_q <= scr_d;
      dll_q <= dll_d;
      dlm_q <= dlm_d;
    end
  end

endmodule

@@ rtl/u8250_checker.sv @@
// Port-level checks for the UART register model, bound to the top level.
module u8250_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       s_axis_tvalid,
  input logic       s_axis_tready,
  input logic       m_axis_tvalid,
  input logic       m_axis_tready,
  input logic [7:0] m_axis_tdata,
  input logic       m_axis_tuser
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser))
    else $error("result changed while stalled");

  // a miss never returns data
  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == 8'h00)
    else $error("miss returned nonzero data");

  // empty result stage never blocks the input
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with empty output");

  // a result appears only after an input transaction
  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid && !(s_axis_tvalid && s_axis_tready)
      ##1 !m_axis_tvalid && !(s_axis_tvalid && s_axis_tready)
      |=> !m_axis_tvalid)
    else $error("result without input transaction");

endmodule

bind uart_8250_register_model u8250_checker u_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .s_axis_tvalid(s_axis_tvalid),
  .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata),
  .m_axis_tuser (m_axis_tuser)
);

@@ verif/testbench.sv @@
`timescale 1ns / 1ps
// Stream-level testbench for the 8250 UART register model: directed accesses, then random ones.
module testbench;
  import u8250_pkg::*;

  localparam logic [15:0] UART_BASE  = 16'h03F8;
  localparam int          NUM_RANDOM = 1700;
  localparam int          CYCLE_LIMIT = 400000;
  localparam int          NUM_ROWS   = 27;

  typedef struct {
    op_e         op;
    logic [15:0] port;
    logic [7:0]  wd;
    bit          typed;
    logic [7:0]  rd;
    logic        hit;
  } step_row_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata;   // [15:0] port, [23:16] write_data
  logic        s_axis_tuser;   // [0] op
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [7:0]  m_axis_tdata;   // [7:0] read_data
  logic        m_axis_tuser;   // [0] hit

  // shadow copy of the UART registers
  logic [7:0] rbr, thr, ier, iir, lcr, mcr, lsr, msr, scr, dll, dlm;

  result_t   pending_results[$];
  step_row_t directed_steps[NUM_ROWS];
  int        errors;
  int        cycles;
  int        n_reads, n_writes, n_misses, n_mouse, n_overrun;

  uart_8250_register_model uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("%0t timeout after %0d cycles", $realtime, cycles);
      $display("tb: failure");
      $finish;
    end
  end

  function automatic void uart_regs_reset();
    rbr = '0; thr = '0; ier = '0; iir = IIR_IDLE; lcr = '0; mcr = '0;
    lsr = LSR_TX_EMPTY; msr = MSR_RESET; scr = '0; dll = '0; dlm = '0;
  endfunction

  // Applies one bus access to the shadow registers and returns its result.
  function automatic result_t uart_access(access_t a);
    result_t    r;
    reg_off_e   off;
    logic       dlab;
    logic [7:0] rising;
    r.read_data = '0;
    r.hit       = (a.port >= UART_BASE) && (a.port <= UART_BASE + 16'd7);
    off         = reg_off_e'(a.port[2:0]);
    dlab        = (lcr & DLAB_BIT) != 0;
    if (!r.hit) begin
      n_misses++;
    end else if (a.op == OP_WRITE) begin
      n_writes++;
      case (off)
        OFF_RBR: begin
          if (dlab) begin
            dll = a.write_data;
          end else begin
            thr = a.write_data;
            lsr = lsr & ~LSR_TX_EMPTY;
          end
        end
        OFF_IER: begin
          if (dlab) dlm = a.write_data; else ier = a.write_data;
        end
        OFF_IIR: ;
        OFF_LCR: lcr = a.write_data;
        OFF_MCR: begin
          rising = ~mcr & a.write_data;
          mcr    = a.write_data;
          // mouse identify: RTS rising pushes 'M' whatever DLAB is
          if ((rising & MCR_RTS) != 0) begin
            n_mouse++;
            rbr = MOUSE_ID;
            if ((lsr & LSR_DR) != 0) begin
              lsr = lsr | LSR_OE;
              n_overrun++;
            end
            lsr = lsr | LSR_DR;
          end
        end
        OFF_LSR: lsr = a.write_data;
        OFF_MSR: msr = a.write_data;
        OFF_SCR: scr = a.write_data;
        default: ;
      endcase
    end else begin
      n_reads++;
      case (off)
        OFF_RBR: begin
          if (dlab) begin
            r.read_data = dll;
          end else begin
            r.read_data = rbr;
            lsr         = lsr & ~LSR_DR;
          end
        end
        OFF_IER: r.read_data = dlab ? dlm : ier;
        OFF_IIR: begin
          r.read_data = iir;
          iir         = IIR_IDLE;
        end
        OFF_LCR: r.read_data = lcr;
        OFF_MCR: r.read_data = mcr;
        OFF_LSR: begin
          r.read_data = lsr;
          lsr         = lsr & LSR_KEEP_MASK;
        end
        OFF_MSR: r.read_data = msr;
        default: r.read_data = scr;
      endcase
    end
    return r;
  endfunction

  function automatic int pick_gap(bit quiet);
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 60) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic access_t random_access();
    access_t a;
    int      r;
    r            = $urandom_range(0, 99);
    a.op         = op_e'($urandom_range(0, 1));
    a.write_data = 8'($urandom_range(0, 255));
    if (r < 85)      a.port = 16'(UART_BASE + $urandom_range(0, 7));
    else if (r < 93) a.port = 16'($urandom_range(16'h03F0, 16'h0407));
    else             a.port = 16'($urandom_range(0, 16'hFFFF));
    return a;
  endfunction

  // Drives one access and waits until the block takes it.
  task automatic send_access(access_t a, int gap);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {a.write_data, a.port};
    s_axis_tuser  <= a.op;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  // Result side: bursts of always-ready, random stalls and the odd long stall.
  initial begin
    int mode;
    int len;
    int stall_left;
    m_axis_tready <= 1'b0;
    stall_left = 0;
    @(posedge rst_ni);
    forever begin
      mode = $urandom_range(0, 3);
      len  = $urandom_range(20, 200);
      repeat (len) begin
        @(posedge clk_i);
        if (stall_left > 0) begin
          m_axis_tready <= 1'b0;
          stall_left--;
        end else if (mode == 0) begin
          m_axis_tready <= 1'b1;
        end else if (mode == 3 && $urandom_range(0, 19) == 0) begin
          m_axis_tready <= 1'b0;
          stall_left = $urandom_range(8, 40);
        end else begin
          m_axis_tready <= ($urandom_range(0, 3) != 0);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_results.size() == 0) begin
        $display("%0t unexpected result: actual rd=%h hit=%b",
                 $realtime, m_axis_tdata, m_axis_tuser);
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (m_axis_tdata !== want.read_data || m_axis_tuser !== want.hit) begin
          $display("%0t mismatch: expected rd=%h hit=%b, actual rd=%h hit=%b",
                   $realtime, want.read_data, want.hit, m_axis_tdata, m_axis_tuser);
          errors++;
        end
      end
    end
  end

  initial begin
    access_t a;
    result_t r;
    bit      quiet;
    errors = 0; cycles = 0;
    n_reads = 0; n_writes = 0; n_misses = 0; n_mouse = 0; n_overrun = 0;
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= 1'b0;
    uart_regs_reset();

    directed_steps = '{
      '{OP_READ,  {UART_PAGE, OFF_IIR}, 8'h00, 1'b1, IIR_IDLE,     1'b1},
      '{OP_READ,  {UART_PAGE, OFF_LSR}, 8'h00, 1'b1, LSR_TX_EMPTY, 1'b1},
      '{OP_READ,  {UART_PAGE, OFF_MSR}, 8'h00, 1'b1, MSR_RESET,    1'b1},
      '{OP_READ,  {UART_PAGE, OFF_RBR}, 8'h00, 1'b1, 8'h00,        1'b1},
      '{OP_READ,  16'h0000,             8'h00, 1'b1, 8'h00,        1'b0},
      '{OP_WRITE, 16'hFFFF,             8'hFF, 1'b1, 8'h00,        1'b0},
      '{OP_READ,  16'h03F7,             8'hFF, 1'b1, 8'h00,        1'b0},
      '{OP_READ,  16'h0400,             8'h00, 1'b1, 8'h00,        1'b0},
      '{OP_WRITE, {UART_PAGE, OFF_SCR}, 8'hFF, 1'b1, 8'h00,        1'b1},
      '{OP_READ,  {UART_PAGE, OFF_SCR}, 8'h00, 1'b1, 8'hFF,        1'b1},
      '{OP_WRITE, {UART_PAGE, OFF_IIR}, 8'hAA, 1'b1, 8'h00,        1'b1},
      '{OP_WRITE, {UART_PAGE, OFF_MCR}, 8'h02, 1'b1, 8'h00,        1'b1},
      '{OP_READ,  {UART_PAGE, OFF_LSR}, 8'h00, 1'b0, 8'h00,        1'b0},
      '{OP_WRITE, {UART_PAGE, OFF_MCR}, 8'h00, 1'b1, 8'h00,        1'b1},
      '{OP_WRITE, {UART_PAGE, OFF_MCR}, 8'h02, 1'b1, 8'h00,        1'b1},
      '{OP_READ,  {UART_PAGE, OFF_LSR}, 8'h00, 1'b0, 8'h00,        1'b0},
      '{OP_READ,  {UART_PAGE, OFF_RBR}, 8'h00, 1'b1, MOUSE_ID,     1'b1},
      '{OP_WRITE, {UART_PAGE, OFF_RBR}, 8'h55, 1'b1, 8'h00,        1'b1},
      '{OP_READ,  {UART_PAGE, OFF_LSR}, 8'h00, 1'b0, 8'h00,        1'b0},
      '{OP_WRITE, {UART_PAGE, OFF_LCR}, 8'h80, 1'b1, 8'h00,        1'b1},
      '{OP_WRITE, {UART_PAGE, OFF_RBR}, 8'h12, 1'b1, 8'h00,        1'b1},
      '{OP_WRITE, {UART_PAGE, OFF_IER}, 8'h34, 1'b1, 8'h00,        1'b1},
      '{OP_WRITE, {UART_PAGE, OFF_MCR}, 8'h00, 1'b0, 8'h00,        1'b0},
      '{OP_WRITE, {UART_PAGE, OFF_MCR}, 8'h02, 1'b0, 8'h00,        1'b0},
      '{OP_READ,  {UART_PAGE, OFF_RBR}, 8'h00, 1'b1, 8'h12,        1'b1},
      '{OP_READ,  {UART_PAGE, OFF_IER}, 8'h00, 1'b1, 8'h34,        1'b1},
      '{OP_WRITE, {UART_PAGE, OFF_LCR}, 8'h03, 1'b0, 8'h00,        1'b0}
    };

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_steps[i]) begin
      a.op         = directed_steps[i].op;
      a.port       = directed_steps[i].port;
      a.write_data = directed_steps[i].wd;
      r = uart_access(a);
      if (directed_steps[i].typed) begin
        r.read_data = directed_steps[i].rd;
        r.hit       = directed_steps[i].hit;
      end
      pending_results.push_back(r);
      send_access(a, (i % 5 == 4) ? 2 : 0);
    end

    quiet = 1'b0;
    for (int n = 0; n < NUM_RANDOM; n++) begin
      if (n % 64 == 0) quiet = ($urandom_range(0, 2) == 0);
      a = random_access();
      pending_results.push_back(uart_access(a));
      send_access(a, pick_gap(quiet));
    end
    s_axis_tvalid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);

    $display("covered %0d accesses: %0d reads, %0d writes, %0d outside the window",
             n_reads + n_writes + n_misses, n_reads, n_writes, n_misses);
    $display("mouse identify seen %0d times, %0d of them with overrun", n_mouse, n_overrun);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
